[src/macd_pkg.sv]
`default_nettype none

package macd_pkg;

  // Number formats
  localparam int unsigned PRICE_BITS  = 32;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned PERIOD_MAX  = 1024;
  localparam int unsigned WEIGHT_BITS = 24;

  // Derived widths
  localparam int unsigned PERIOD_W = 11;                        // period and count width
  localparam int unsigned AVG_W    = PRICE_BITS + FRAC_BITS;    // fast/slow average, unsigned
  localparam int unsigned LINE_W   = AVG_W + 1;                 // MACD and signal, signed
  localparam int unsigned HIST_W   = AVG_W + 2;                 // histogram, signed
  localparam int unsigned EMA_W    = AVG_W + 2;                 // EMA unit operand, signed
  localparam int unsigned MAG_W    = EMA_W - 1;                 // |x - avg|
  localparam int unsigned W_W      = WEIGHT_BITS + 1;           // Q0.24 weight, 1.0 included
  localparam int unsigned HI_W     = MAG_W - WEIGHT_BITS;
  localparam int unsigned MA_W     = (HI_W > WEIGHT_BITS) ? HI_W : WEIGHT_BITS;
  localparam int unsigned PROD_W   = MA_W + W_W;
  localparam int unsigned Q_W      = PERIOD_W + 1;              // divisor period + 1
  localparam int unsigned DIV_N_W  = WEIGHT_BITS + 2;           // dividend 2^25 + q/2
  localparam int unsigned DIV_C_W  = $clog2(DIV_N_W);

  // APB
  localparam int unsigned APB_DW  = 32;
  localparam int unsigned APB_AW  = 4;
  localparam int unsigned REG_NUM = 3;

  localparam logic [PERIOD_W-1:0] PERIOD_LIM = PERIOD_W'(PERIOD_MAX);
  localparam logic [PERIOD_W-1:0] COUNT_MAX  = '1;
  localparam logic [PERIOD_W-1:0] FAST_RST   = PERIOD_W'(12);
  localparam logic [PERIOD_W-1:0] SLOW_RST   = PERIOD_W'(26);
  localparam logic [PERIOD_W-1:0] SIGNAL_RST = PERIOD_W'(9);

  typedef enum logic [1:0] {
    REG_FAST,
    REG_SLOW,
    REG_SIGNAL
  } reg_idx_e;

  typedef enum logic [2:0] {
    EMA_IDLE,
    EMA_LO,
    EMA_HI,
    EMA_SUM,
    EMA_DONE
  } ema_state_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WDIV,
    ST_LOAD,
    ST_FAST,
    ST_SLOW,
    ST_MACD,
    ST_SIG,
    ST_OUT
  } top_state_e;

  // Operands handed to the shared EMA unit
  typedef struct packed {
    logic signed [EMA_W-1:0] avg;
    logic signed [EMA_W-1:0] x;
    logic [W_W-1:0]          weight;
  } ema_op_t;

  function automatic logic [PERIOD_W-1:0] clamp_period(input logic [PERIOD_W-1:0] p);
    return (p > PERIOD_LIM) ? PERIOD_LIM : p;
  endfunction

  function automatic logic [PERIOD_W-1:0] sat_inc(input logic [PERIOD_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + PERIOD_W'(1);
  endfunction

endpackage

`default_nettype wire

[src/macd_wdiv.sv]
`default_nettype none

// Restoring divider for the EMA weight: round(2^25 / (P + 1)), one bit per cycle.
module macd_wdiv import macd_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [PERIOD_W-1:0] period_i,
  output logic                     done_o,
  output logic [W_W-1:0]           weight_o
);

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [DIV_C_W-1:0]  cnt_q, cnt_d;
  logic [DIV_N_W-1:0]  n_q, n_d;
  logic [Q_W-1:0]      rem_q, rem_d;
  logic [Q_W-1:0]      q_q, q_d;

  logic [PERIOD_W-1:0] pc;
  logic [PERIOD_W-1:0] pe;
  logic [Q_W-1:0]      q_start;
  logic [Q_W:0]        trial;
  logic [Q_W:0]        diff;
  logic                ge;

  // period 0 weighs as period 1
  assign pc      = clamp_period(period_i);
  assign pe      = (pc == '0) ? PERIOD_W'(1) : pc;
  assign q_start = {1'b0, pe} + Q_W'(1);

  assign trial = {rem_q, n_q[DIV_N_W-1]};
  assign diff  = trial - {1'b0, q_q};
  assign ge    = (trial >= {1'b0, q_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    n_d    = n_q;
    rem_d  = rem_q;
    q_d    = q_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = DIV_C_W'(DIV_N_W - 1);
      n_d    = (DIV_N_W'(1) << (WEIGHT_BITS + 1)) + DIV_N_W'(q_start >> 1);
      rem_d  = '0;
      q_d    = q_start;
    end else if (busy_q) begin
      n_d   = {n_q[DIV_N_W-2:0], ge};
      rem_d = ge ? diff[Q_W-1:0] : trial[Q_W-1:0];
      cnt_d = cnt_q - DIV_C_W'(1);
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    n_q   <= n_d;
    rem_q <= rem_d;
    q_q   <= q_d;
  end

  // quotient never exceeds 2^24
  assign done_o   = done_q;
  assign weight_o = n_q[W_W-1:0];

endmodule

`default_nettype wire

[src/macd_ema.sv]
`default_nettype none

// Shared EMA update: avg + round(w * (x - avg) / 2^24), ties away from zero.
// One multiplier, used for the low and then the high half of |x - avg|.
module macd_ema import macd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire ema_op_t           op_i,
  output logic                   done_o,
  output logic signed [EMA_W-1:0] result_o
);

  localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(1) << (WEIGHT_BITS - 1);

  ema_state_e state_q, state_d;

  logic signed [EMA_W-1:0] avg_q;
  logic [MAG_W-1:0]        mag_q;
  logic                    neg_q;
  logic [W_W-1:0]          w_q;
  logic [PROD_W-1:0]       prodlo_q;
  logic [PROD_W-1:0]       prodhi_q;
  logic signed [EMA_W-1:0] res_q;

  logic signed [EMA_W-1:0] diff;
  logic [EMA_W-1:0]        diff_abs;
  logic [MA_W-1:0]         mult_a;
  logic [PROD_W-1:0]       prod;
  logic [PROD_W:0]         lo_sum;
  logic [EMA_W-1:0]        step;
  logic                    take;

  assign diff     = op_i.x - op_i.avg;
  assign diff_abs = diff[EMA_W-1] ? -diff : diff;

  // a new update may start in the cycle that ends the previous one
  assign take = start_i && (state_q == EMA_IDLE || state_q == EMA_DONE);

  // multiplier operand: low digit first, then high digit
  assign mult_a = (state_q == EMA_LO) ? MA_W'(mag_q[WEIGHT_BITS-1:0])
                                      : MA_W'(mag_q[MAG_W-1:WEIGHT_BITS]);
  assign prod   = PROD_W'(mult_a) * PROD_W'(w_q);

  assign lo_sum = {1'b0, prodlo_q} + ROUND_HALF;
  assign step   = EMA_W'(prodhi_q) + EMA_W'(lo_sum[PROD_W:WEIGHT_BITS]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      EMA_IDLE: if (start_i) state_d = EMA_LO;
      EMA_LO:   state_d = EMA_HI;
      EMA_HI:   state_d = EMA_SUM;
      EMA_SUM:  state_d = EMA_DONE;
      EMA_DONE: state_d = start_i ? EMA_LO : EMA_IDLE;
      default:  state_d = EMA_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= EMA_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      avg_q <= op_i.avg;
      neg_q <= diff[EMA_W-1];
      mag_q <= diff_abs[MAG_W-1:0];
      w_q   <= op_i.weight;
    end
    if (state_q == EMA_LO) prodlo_q <= prod;
    if (state_q == EMA_HI) prodhi_q <= prod;
    if (state_q == EMA_SUM) res_q <= neg_q ? avg_q - signed'(step) : avg_q + signed'(step);
  end

  assign done_o   = (state_q == EMA_DONE);
  assign result_o = res_q;

endmodule

`default_nettype wire

[src/macd_indicator_top.sv]
`default_nettype none

// MACD indicator: one price word in, one result word out (MACD line, signal
// line, histogram, valid bits); lines in signed Q32.16, histogram in signed
// Q33.16. Fast, slow and signal EMAs use the weight 2/(P+1) in Q0.24 from
// the three period registers (APB, byte addresses 0x0, 0x4, 0x8). A regular
// price runs from acceptance to the next ready through the three EMA
// updates, one after another on a single shared multiplier, plus load,
// MACD and output steps; the signal update is skipped while the MACD is
// not yet valid or at its first valid value, and the first price of a
// series runs no EMA update. After reset and after each period write the
// block recomputes that period's weight with a bit-serial divider and
// holds in_ready_o low meanwhile. A finished result waits in an output
// register; while it is not taken the block stalls before its output step.
module macd_indicator_top import macd_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // price channel
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [31:0]        price_i,
  input  wire logic               start_series_i,
  // result channel
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [48:0]      macd_line_o,
  output logic signed [48:0]      signal_line_o,
  output logic signed [49:0]      histogram_o,
  output logic                    macd_valid_o,
  output logic                    signal_valid_o,
  // configuration
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [APB_AW-1:0]  paddr,
  input  wire logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]       prdata,
  output logic                    pready
);

  top_state_e state_q, state_d;

  // configuration and weights
  logic [PERIOD_W-1:0] fast_p_q, slow_p_q, sig_p_q;
  logic [W_W-1:0]      w_fast_q, w_slow_q, w_sig_q;
  logic [REG_NUM-1:0]  stale_q, stale_d;
  reg_idx_e            widx_q, widx_d;

  // series state
  logic [AVG_W-1:0]         x_q, x_d;
  logic                     first_q, first_d;
  logic [AVG_W-1:0]         fast_avg_q, fast_avg_d;
  logic [AVG_W-1:0]         slow_avg_q, slow_avg_d;
  logic signed [LINE_W-1:0] sig_avg_q, sig_avg_d;
  logic [PERIOD_W-1:0]      scount_q, scount_d;
  logic [PERIOD_W-1:0]      mcount_q, mcount_d;
  logic signed [LINE_W-1:0] macd_q, macd_d;
  logic                     mv_q, mv_d;

  // output register
  logic                     ovalid_q, ovalid_d;
  logic                     oload;
  logic signed [LINE_W-1:0] omacd_q, osig_q;
  logic signed [HIST_W-1:0] ohist_q;
  logic                     omv_q, osv_q;

  // APB decode
  logic     wr_en;
  reg_idx_e wr_idx;
  reg_idx_e rd_idx;

  // shared units
  logic                    div_start;
  logic [PERIOD_W-1:0]     div_period;
  logic                    div_done;
  logic [W_W-1:0]          div_weight;
  logic                    ema_start;
  ema_op_t                 ema_op;
  logic                    ema_done;
  logic signed [EMA_W-1:0] ema_res;

  // combinational MACD and output terms
  logic                     fast_ok, mv_c, sv_c;
  logic [AVG_W-1:0]         f_term, s_term;
  logic signed [LINE_W-1:0] macd_c, sig_c;
  logic signed [HIST_W-1:0] hist_c;

  macd_wdiv u_wdiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (div_start),
    .period_i (div_period),
    .done_o   (div_done),
    .weight_o (div_weight)
  );

  macd_ema u_ema (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (ema_start),
    .op_i     (ema_op),
    .done_o   (ema_done),
    .result_o (ema_res)
  );

  // APB: zero wait states
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_idx = reg_idx_e'(paddr[3:2]);
  assign rd_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    case (rd_idx)
      REG_FAST:   prdata = APB_DW'(fast_p_q);
      REG_SLOW:   prdata = APB_DW'(slow_p_q);
      REG_SIGNAL: prdata = APB_DW'(sig_p_q);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_p_q <= FAST_RST;
      slow_p_q <= SLOW_RST;
      sig_p_q  <= SIGNAL_RST;
    end else if (wr_en) begin
      case (wr_idx)
        REG_FAST:   fast_p_q <= pwdata[PERIOD_W-1:0];
        REG_SLOW:   slow_p_q <= pwdata[PERIOD_W-1:0];
        REG_SIGNAL: sig_p_q  <= pwdata[PERIOD_W-1:0];
        default:    ;
      endcase
    end
  end

  // MACD terms from the updated averages and counts
  assign fast_ok = (fast_p_q != '0) && (scount_q >= clamp_period(fast_p_q));
  assign mv_c    = (scount_q >= clamp_period(slow_p_q));
  assign f_term  = fast_ok ? fast_avg_q : '0;
  assign s_term  = (slow_p_q != '0) ? slow_avg_q : '0;
  assign macd_c  = signed'({1'b0, f_term}) - signed'({1'b0, s_term});

  // output terms
  assign sv_c   = mv_q && (sig_p_q != '0) && (mcount_q >= clamp_period(sig_p_q));
  assign sig_c  = sv_c ? sig_avg_q : '0;
  assign hist_c = signed'({macd_q[LINE_W-1], macd_q}) - signed'({sig_c[LINE_W-1], sig_c});

  // sequencer
  always_comb begin
    state_d    = state_q;
    stale_d    = stale_q;
    widx_d     = widx_q;
    x_d        = x_q;
    first_d    = first_q;
    fast_avg_d = fast_avg_q;
    slow_avg_d = slow_avg_q;
    sig_avg_d  = sig_avg_q;
    scount_d   = scount_q;
    mcount_d   = mcount_q;
    macd_d     = macd_q;
    mv_d       = mv_q;
    in_ready_o = 1'b0;
    oload      = 1'b0;
    div_start  = 1'b0;
    div_period = fast_p_q;
    ema_start  = 1'b0;
    ema_op.avg    = signed'({2'b00, fast_avg_q});
    ema_op.x      = signed'({2'b00, x_q});
    ema_op.weight = w_fast_q;

    case (state_q)
      ST_IDLE: begin
        if (stale_q != '0) begin
          div_start = 1'b1;
          if (stale_q[REG_FAST]) begin
            widx_d     = REG_FAST;
            div_period = fast_p_q;
          end else if (stale_q[REG_SLOW]) begin
            widx_d     = REG_SLOW;
            div_period = slow_p_q;
          end else begin
            widx_d     = REG_SIGNAL;
            div_period = sig_p_q;
          end
          state_d = ST_WDIV;
        end else begin
          in_ready_o = 1'b1;
          if (in_valid_i) begin
            x_d     = {price_i[PRICE_BITS-1:0], FRAC_BITS'(0)};
            first_d = start_series_i || (scount_q == '0);
            state_d = ST_LOAD;
          end
        end
      end
      ST_WDIV: begin
        if (div_done) begin
          stale_d[widx_q] = 1'b0;
          state_d         = ST_IDLE;
        end
      end
      ST_LOAD: begin
        if (first_q) begin
          fast_avg_d = x_q;
          slow_avg_d = x_q;
          scount_d   = PERIOD_W'(1);
          mcount_d   = '0;
          sig_avg_d  = '0;
          state_d    = ST_MACD;
        end else begin
          ema_start = 1'b1;
          state_d   = ST_FAST;
        end
      end
      ST_FAST: begin
        if (ema_done) begin
          fast_avg_d    = ema_res[AVG_W-1:0];
          ema_start     = 1'b1;
          ema_op.avg    = signed'({2'b00, slow_avg_q});
          ema_op.weight = w_slow_q;
          state_d       = ST_SLOW;
        end
      end
      ST_SLOW: begin
        if (ema_done) begin
          slow_avg_d = ema_res[AVG_W-1:0];
          scount_d   = sat_inc(scount_q);
          state_d    = ST_MACD;
        end
      end
      ST_MACD: begin
        mv_d    = mv_c;
        macd_d  = mv_c ? macd_c : '0;
        state_d = ST_OUT;
        if (mv_c) begin
          mcount_d = sat_inc(mcount_q);
          if (mcount_q == '0) begin
            sig_avg_d = macd_c;
          end else begin
            ema_start     = 1'b1;
            ema_op.avg    = signed'({sig_avg_q[LINE_W-1], sig_avg_q});
            ema_op.x      = signed'({macd_c[LINE_W-1], macd_c});
            ema_op.weight = w_sig_q;
            state_d       = ST_SIG;
          end
        end
      end
      ST_SIG: begin
        if (ema_done) begin
          sig_avg_d = ema_res[LINE_W-1:0];
          state_d   = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!ovalid_q || out_ready_i) begin
          oload   = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    // a write marks its weight for recomputation
    if (wr_en) begin
      case (wr_idx)
        REG_FAST:   stale_d[REG_FAST]   = 1'b1;
        REG_SLOW:   stale_d[REG_SLOW]   = 1'b1;
        REG_SIGNAL: stale_d[REG_SIGNAL] = 1'b1;
        default:    ;
      endcase
    end
  end

  // output handshake
  always_comb begin
    ovalid_d = ovalid_q && !out_ready_i;
    if (oload) ovalid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      stale_q  <= '1;
      widx_q   <= REG_FAST;
      scount_q <= '0;
      mcount_q <= '0;
      ovalid_q <= 1'b0;
      first_q  <= 1'b0;
      mv_q     <= 1'b0;
    end else begin
      state_q  <= state_d;
      stale_q  <= stale_d;
      widx_q   <= widx_d;
      scount_q <= scount_d;
      mcount_q <= mcount_d;
      ovalid_q <= ovalid_d;
      first_q  <= first_d;
      mv_q     <= mv_d;
    end
  end

  // averages reset to zero with the counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_avg_q <= '0;
      slow_avg_q <= '0;
      sig_avg_q  <= '0;
    end else begin
      fast_avg_q <= fast_avg_d;
      slow_avg_q <= slow_avg_d;
      sig_avg_q  <= sig_avg_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    macd_q <= macd_d;
    if (state_q == ST_WDIV && div_done) begin
      case (widx_q)
        REG_FAST:   w_fast_q <= div_weight;
        REG_SLOW:   w_slow_q <= div_weight;
        REG_SIGNAL: w_sig_q  <= div_weight;
        default:    ;
      endcase
    end
    if (oload) begin
      omacd_q <= macd_q;
      osig_q  <= sig_c;
      ohist_q <= hist_c;
      omv_q   <= mv_q;
      osv_q   <= sv_c;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign macd_line_o    = omacd_q;
  assign signal_line_o  = osig_q;
  assign histogram_o    = ohist_q;
  assign macd_valid_o   = omv_q;
  assign signal_valid_o = osv_q;

endmodule

`default_nettype wire

[src/macd_checker.sv]
`default_nettype none

// Port-level checks on the MACD block
module macd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire logic signed [48:0] macd_line_o,
  input wire logic signed [48:0] signal_line_o,
  input wire logic signed [49:0] histogram_o,
  input wire logic               macd_valid_o,
  input wire logic               signal_valid_o
);

  // one price word at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready stayed high after a price word was taken");

  // a stalled result word stays valid and keeps its histogram and MACD line
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(histogram_o) && $stable(macd_line_o))
    else $error("result word changed while stalled");

  // lines are zero before the MACD is valid
  a_zero_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !macd_valid_o |->
      macd_line_o == '0 && signal_line_o == '0 && histogram_o == '0 && !signal_valid_o)
    else $error("non-zero lines on an invalid MACD word");

  // signal line only shown when valid
  a_signal_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !signal_valid_o |-> signal_line_o == '0)
    else $error("signal line non-zero while not valid");

  // histogram is MACD minus signal
  a_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      histogram_o == ({macd_line_o[48], macd_line_o} - {signal_line_o[48], signal_line_o}))
    else $error("histogram does not match MACD minus signal");

endmodule

bind macd_indicator_top macd_checker u_macd_checker (.*);

`default_nettype wire
